// ===== rtl/trimmed_mean_duty_regulator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Trimmed-mean duty regulator assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_DUTY_REGULATOR_CORE_DEFINES_SVH
`define TRIMMED_MEAN_DUTY_REGULATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define TMDR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tmdr: same-cycle check failed");

// Next-cycle implication; pass 1'b0 as rst to keep it live through reset.
`define TMDR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tmdr: next-cycle check failed");

`endif

// ===== rtl/tmdr_pkg.sv =====
// ----------------------------------------------------------------------------
// tmdr_pkg
// Constants and types for the trimmed-mean duty regulator.
// ----------------------------------------------------------------------------
package tmdr_pkg;

  localparam int LEVEL_BITS = 12;
  localparam int DUTY_BITS  = 7;
  localparam int SUM_BITS   = 16;
  localparam int CNT_BITS   = 4;
  localparam int RUN_BITS   = 8;

  localparam logic [CNT_BITS-1:0] WINDOW_LEN  = 4'd10;
  localparam int                  TRIM_SHIFT  = 3;
  localparam logic [RUN_BITS-1:0] COUNT_LIMIT = 8'd5;

  localparam logic [LEVEL_BITS-1:0] HIGH_LIMIT_RST   = 12'd4095;
  localparam logic [LEVEL_BITS-1:0] LOW_LIMIT_RST    = 12'd0;
  localparam logic [DUTY_BITS-1:0]  DUTY_CEILING_RST = 7'd74;
  localparam logic [DUTY_BITS-1:0]  DUTY_FLOOR_RST   = 7'd1;

  localparam int OUT_DATA_BITS = 24;
  localparam int OUT_USER_BITS = 1;

  typedef enum logic [1:0] {
    REG_HIGH_LIMIT   = 2'd0,
    REG_LOW_LIMIT    = 2'd1,
    REG_DUTY_CEILING = 2'd2,
    REG_DUTY_FLOOR   = 2'd3
  } reg_idx_t;

endpackage

// ===== rtl/trimmed_mean_duty_regulator_core.sv =====
// ----------------------------------------------------------------------------
// trimmed_mean_duty_regulator_core
// Trimmed-mean level filter over windows of ten samples, driving a
// bang-bang duty regulator.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one converter sample per item (s_tdata, low bits).
//   m_* returns one result item per sample: m_tdata holds filtered_level
//   and duty, m_tuser flags a sample that closed a window.
//   The APB port sets the limits, duty ceiling and floor; write it only
//   while no item is in flight.
// Path: a sample is taken into the input register, then its result into
//   the result register. Throughput: one item per cycle while the result
//   is not stalled; the whole window and regulator update is one
//   combinational pass between the two registers.
// Stall: while m_tready is low the result holds; an empty input register
//   can still take one more item, then s_tready drops until the result
//   leaves.
// Reset: rst (synchronous) empties both registers, clears window, level,
//   duty and run counters to zero and loads register defaults.
// ----------------------------------------------------------------------------
module trimmed_mean_duty_regulator_core #(
  parameter int SAMPLE_BITS = 12,
  localparam int InWidth = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [InWidth-1:0]                  s_tdata,  // [SAMPLE_BITS-1:0] sample, rest zero
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tmdr_pkg::OUT_DATA_BITS-1:0]  m_tdata,  // [11:0] filtered_level, [18:12] duty
  output logic [tmdr_pkg::OUT_USER_BITS-1:0]  m_tuser,  // [0] level_updated
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int LB = tmdr_pkg::LEVEL_BITS;
  localparam int DB = tmdr_pkg::DUTY_BITS;
  localparam int SB = tmdr_pkg::SUM_BITS;
  localparam int CB = tmdr_pkg::CNT_BITS;
  localparam int RB = tmdr_pkg::RUN_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [LB-1:0] high_limit;
  logic [LB-1:0] low_limit;
  logic [DB-1:0] duty_ceiling;
  logic [DB-1:0] duty_floor;

  tmdr_pkg::reg_idx_t reg_idx;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = tmdr_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_limit   <= tmdr_pkg::HIGH_LIMIT_RST;
      low_limit    <= tmdr_pkg::LOW_LIMIT_RST;
      duty_ceiling <= tmdr_pkg::DUTY_CEILING_RST;
      duty_floor   <= tmdr_pkg::DUTY_FLOOR_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        tmdr_pkg::REG_HIGH_LIMIT:   high_limit   <= pwdata[LB-1:0];
        tmdr_pkg::REG_LOW_LIMIT:    low_limit    <= pwdata[LB-1:0];
        tmdr_pkg::REG_DUTY_CEILING: duty_ceiling <= pwdata[DB-1:0];
        tmdr_pkg::REG_DUTY_FLOOR:   duty_floor   <= pwdata[DB-1:0];
        default: ;
      endcase
    end
  end

  // Read back: zero-extend the selected register.
  always_comb begin
    case (reg_idx)
      tmdr_pkg::REG_HIGH_LIMIT:   prdata = 32'(high_limit);
      tmdr_pkg::REG_LOW_LIMIT:    prdata = 32'(low_limit);
      tmdr_pkg::REG_DUTY_CEILING: prdata = 32'(duty_ceiling);
      tmdr_pkg::REG_DUTY_FLOOR:   prdata = 32'(duty_floor);
      default:                    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic                   in_valid;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   advance;   // result register may load
  logic                   fire;      // an item is processed this cycle

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign fire     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sample <= s_tdata[SAMPLE_BITS-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Window and regulator state
  // --------------------------------------------------------------------------
  logic [CB-1:0]          window_count, window_count_next;
  logic [SB-1:0]          window_sum, window_sum_next;
  logic [SAMPLE_BITS-1:0] window_max, window_max_next;
  logic [SAMPLE_BITS-1:0] window_min, window_min_next;
  logic [LB-1:0]          held_level, held_level_next;
  logic [DB-1:0]          duty_value, duty_value_next;
  logic [RB-1:0]          over_count, over_count_next;
  logic [RB-1:0]          under_count, under_count_next;
  logic                   updated;

  logic [SAMPLE_BITS-1:0] run_max;
  logic [SAMPLE_BITS-1:0] run_min;
  logic [SB-1:0]          run_sum;
  logic [CB-1:0]          run_count;
  logic [SB-1:0]          trimmed;
  logic [RB-1:0]          over_inc;
  logic [RB-1:0]          under_inc;

  always_comb begin
    // Window collection: first sample seeds both extremes; a new maximum
    // skips the minimum test.
    run_max = window_max;
    run_min = window_min;
    if (window_count == '0) begin
      run_max = in_sample;
      run_min = in_sample;
    end else if (in_sample > window_max) begin
      run_max = in_sample;
    end else if (in_sample < window_min) begin
      run_min = in_sample;
    end
    run_sum   = window_sum + SB'(in_sample);
    run_count = window_count + CB'(1);
    // Drop both extremes, wrapping at the sum width, then scale by 1/8.
    trimmed   = run_sum - SB'(run_max) - SB'(run_min);

    updated           = (run_count >= tmdr_pkg::WINDOW_LEN);
    window_max_next   = run_max;
    window_min_next   = run_min;
    window_sum_next   = run_sum;
    window_count_next = run_count;
    held_level_next   = held_level;
    if (updated) begin
      held_level_next   = trimmed[tmdr_pkg::TRIM_SHIFT +: LB];
      window_max_next   = '0;
      window_min_next   = '0;
      window_sum_next   = '0;
      window_count_next = '0;
    end

    // Bang-bang regulation on the level after this step's update.
    over_inc         = over_count + RB'(1);
    under_inc        = under_count + RB'(1);
    over_count_next  = over_count;
    under_count_next = under_count;
    duty_value_next  = duty_value;
    if (held_level_next > high_limit) begin
      under_count_next = '0;
      if (over_inc > tmdr_pkg::COUNT_LIMIT) begin
        over_count_next = '0;
        if (duty_value > duty_floor) begin
          duty_value_next = duty_value - DB'(1);
        end
      end else begin
        over_count_next = over_inc;
      end
    end else if (held_level_next < low_limit) begin
      // Under run is kept across steps and wraps at its width.
      over_count_next  = '0;
      under_count_next = under_inc;
      if (under_inc > tmdr_pkg::COUNT_LIMIT && duty_value < duty_ceiling) begin
        duty_value_next = duty_value + DB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      window_sum   <= '0;
      window_max   <= '0;
      window_min   <= '0;
      held_level   <= '0;
      duty_value   <= '0;
      over_count   <= '0;
      under_count  <= '0;
    end else if (fire) begin
      window_count <= window_count_next;
      window_sum   <= window_sum_next;
      window_max   <= window_max_next;
      window_min   <= window_min_next;
      held_level   <= held_level_next;
      duty_value   <= duty_value_next;
      over_count   <= over_count_next;
      under_count  <= under_count_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= tmdr_pkg::OUT_DATA_BITS'({duty_value_next, held_level_next});
      m_tuser <= updated;
    end
  end

endmodule

// ===== rtl/tmdr_checker.sv =====
// ----------------------------------------------------------------------------
// tmdr_checker
// Port-level checks for the trimmed-mean duty regulator, bound to the top.
// ----------------------------------------------------------------------------
`include "trimmed_mean_duty_regulator_core_defines.svh"

module tmdr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [tmdr_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  input logic [tmdr_pkg::OUT_USER_BITS-1:0]  m_tuser
);

  // Stalled result holds.
  `TMDR_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // Reset empties the result register.
  `TMDR_ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, !m_tvalid)

  // Unused result bits stay zero.
  `TMDR_ASSERT_NOW(a_pad_zero, clk, rst, m_tvalid, m_tdata[23:19] == 5'd0)

  // The level only moves on a result that closed a window.
  `TMDR_ASSERT_NOW(a_level_held, clk, rst,
    $past(m_tvalid && m_tready) && m_tvalid && !m_tuser[0],
    m_tdata[11:0] == $past(m_tdata[11:0]))

endmodule

bind trimmed_mean_duty_regulator_core tmdr_checker u_tmdr_checker (
  .clk(clk), .rst(rst),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Trimmed-mean duty regulator core testbench
// Feeds converter samples over the stream port and programs the limits over
// APB. A local predictor mirrors the window filter and the bang-bang duty
// loop, and every result item is checked field by field, in order. A short
// stimulus table opens the run; random phases with fresh register settings
// follow, under bursty input and a receiver that stalls on its own.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W       = 12;
  localparam int IN_W           = ((SAMPLE_W + 7) / 8) * 8;
  localparam int RESET_CYCLES   = 8;
  localparam int RESULT_LATENCY = 2;
  localparam int END_CYCLES     = 20;
  localparam int RANDOM_ITEMS   = 1950;
  localparam int LONG_HOLD      = 300;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int DIRECTED_ROWS  = 28;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    logic [tmdr_pkg::LEVEL_BITS-1:0] level;
    logic                            updated;
    logic [tmdr_pkg::DUTY_BITS-1:0]  duty;
  } level_result_t;

  // A write row uses sel and value; a sample row uses value as the sample
  // and, when typed is set, want as the result to expect.
  typedef struct packed {
    row_kind_t          kind;
    tmdr_pkg::reg_idx_t sel;
    logic [11:0]        value;
    logic               typed;
    level_result_t      want;
  } stim_row_t;

  // Opening table: drive the under-limit run into the ceiling, then the
  // over-limit run down one step, then stall the cut at a high floor.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_WRITE,  tmdr_pkg::REG_LOW_LIMIT,    12'd4095, 1'b0, '0},
    '{ROW_WRITE,  tmdr_pkg::REG_DUTY_CEILING, 12'd3,    1'b0, '0},
    '{ROW_WRITE,  tmdr_pkg::REG_DUTY_FLOOR,   12'd0,    1'b0, '0},
    // first item of a window seeds min and max; nothing is held yet
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd0,    1'b1, '{12'd0, 1'b0, 7'd0}},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd4095, 1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd2048, 1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd1,    1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd4094, 1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd0,    1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd3000, 1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd17,   1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd4095, 1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd2500, 1'b0, '0},
    // held level now sits above a zero high limit
    '{ROW_WRITE,  tmdr_pkg::REG_HIGH_LIMIT,   12'd0,    1'b0, '0},
    '{ROW_WRITE,  tmdr_pkg::REG_LOW_LIMIT,    12'd0,    1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd4095, 1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd0,    1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd123,  1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd4000, 1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd77,   1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd2222, 1'b0, '0},
    // duty at or below the floor: the cut is skipped, the run still clears
    '{ROW_WRITE,  tmdr_pkg::REG_DUTY_FLOOR,   12'd127,  1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd1,    1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd4094, 1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd2047, 1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd2048, 1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd3,    1'b0, '0},
    '{ROW_SAMPLE, tmdr_pkg::REG_HIGH_LIMIT,   12'd4093, 1'b0, '0}
  };

  // Clock, reset and every DUT input start at known values.
  logic                               clk      = 1'b0;
  logic                               rst      = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [IN_W-1:0]                    s_tdata  = '0;   // [11:0] sample, rest zero
  logic                               m_tvalid;
  logic                               m_tready = 1'b1;
  logic [tmdr_pkg::OUT_DATA_BITS-1:0] m_tdata;         // [11:0] filtered_level, [18:12] duty
  logic [tmdr_pkg::OUT_USER_BITS-1:0] m_tuser;         // [0] level_updated
  logic                               psel     = 1'b0;
  logic                               penable  = 1'b0;
  logic                               pwrite   = 1'b0;
  logic [3:0]                         paddr    = '0;
  logic [31:0]                        pwdata   = '0;
  logic [31:0]                        prdata;
  logic                               pready;

  // Predictor copy of the register file.
  logic [tmdr_pkg::LEVEL_BITS-1:0] cfg_high    = tmdr_pkg::HIGH_LIMIT_RST;
  logic [tmdr_pkg::LEVEL_BITS-1:0] cfg_low     = tmdr_pkg::LOW_LIMIT_RST;
  logic [tmdr_pkg::DUTY_BITS-1:0]  cfg_ceiling = tmdr_pkg::DUTY_CEILING_RST;
  logic [tmdr_pkg::DUTY_BITS-1:0]  cfg_floor   = tmdr_pkg::DUTY_FLOOR_RST;

  // Predictor copy of the filter and regulator state; all clear at reset.
  logic [tmdr_pkg::CNT_BITS-1:0]   win_count  = '0;
  logic [tmdr_pkg::SUM_BITS-1:0]   win_sum    = '0;
  logic [tmdr_pkg::LEVEL_BITS-1:0] win_max    = '0;
  logic [tmdr_pkg::LEVEL_BITS-1:0] win_min    = '0;
  logic [tmdr_pkg::LEVEL_BITS-1:0] held_level = '0;
  logic [tmdr_pkg::DUTY_BITS-1:0]  duty_now   = '0;
  logic [tmdr_pkg::RUN_BITS-1:0]   over_run   = '0;
  logic [tmdr_pkg::RUN_BITS-1:0]   under_run  = '0;

  level_result_t pending_results [$];

  int          error_count     = 0;
  int          samples_sent    = 0;
  int          results_checked = 0;
  int          windows_closed  = 0;
  int          register_writes = 0;
  int          duty_raises     = 0;
  int          duty_cuts       = 0;
  int          under_wraps     = 0;
  int          cycle_count     = 0;
  int unsigned burst_left      = 0;
  int unsigned gap_left        = 0;
  int          hold_asked      = 0;
  int          hold_taken      = 0;

  trimmed_mean_duty_regulator_core #(
    .SAMPLE_BITS(SAMPLE_W)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Advance the predictor by one sample and return the result it causes.
  function automatic level_result_t advance_regulator(
      input logic [tmdr_pkg::LEVEL_BITS-1:0] smp);
    level_result_t                 res;
    logic [tmdr_pkg::SUM_BITS-1:0] trimmed;
    logic [tmdr_pkg::SUM_BITS-1:0] scaled;
    res.updated = 1'b0;
    // window collection: a new maximum skips the minimum compare
    if (win_count == '0) begin
      win_max = smp;
      win_min = smp;
    end else if (smp > win_max) begin
      win_max = smp;
    end else if (smp < win_min) begin
      win_min = smp;
    end
    win_sum   = win_sum + {4'b0, smp};
    win_count = win_count + 1'b1;
    if (win_count >= tmdr_pkg::WINDOW_LEN) begin
      // drop both extremes, divide the rest by eight, restart the window
      trimmed     = win_sum - {4'b0, win_max} - {4'b0, win_min};
      scaled      = trimmed >> tmdr_pkg::TRIM_SHIFT;
      held_level  = scaled[tmdr_pkg::LEVEL_BITS-1:0];
      win_sum     = '0;
      win_max     = '0;
      win_min     = '0;
      win_count   = '0;
      res.updated = 1'b1;
      windows_closed++;
    end
    // bang-bang regulation on the held level
    if (held_level > cfg_high) begin
      over_run = over_run + 1'b1;
      if (over_run > tmdr_pkg::COUNT_LIMIT) begin
        over_run = '0;
        if (duty_now > cfg_floor) begin
          duty_now = duty_now - 1'b1;
          duty_cuts++;
        end
      end
      under_run = '0;
    end else if (held_level < cfg_low) begin
      // the under run is never cleared by a raise; it wraps at 8 bits
      under_run = under_run + 1'b1;
      if (under_run == '0) under_wraps++;
      if (under_run > tmdr_pkg::COUNT_LIMIT && duty_now < cfg_ceiling) begin
        duty_now = duty_now + 1'b1;
        duty_raises++;
      end
      over_run = '0;
    end
    res.level = held_level;
    res.duty  = duty_now;
    return res;
  endfunction

  // Offer one sample, wait for the handshake, record what it must produce.
  // Hold the valid high straight into the next item unless a gap is due.
  task automatic offer_sample(input logic [tmdr_pkg::LEVEL_BITS-1:0] smp,
                              input logic typed, input level_result_t want);
    level_result_t predicted;
    if (gap_left != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - SAMPLE_W){1'b0}}, smp};
    do @(posedge clk); while (!s_tready);
    predicted = advance_regulator(smp);
    pending_results.push_back(typed ? want : predicted);
    samples_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      // new burst; a quarter of them follow on with no gap at all
      burst_left = $urandom_range(1, 40);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
  endtask

  // Drop valid and wait until every expected result has left the block.
  task automatic settle_pipeline();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  // Write one register over APB (junk in the unused bits), update the
  // predictor's copy and read the register back.
  task automatic program_register(input tmdr_pkg::reg_idx_t sel, input logic [11:0] value);
    logic [31:0] word;
    logic [31:0] stored;
    word = $urandom;
    if (sel == tmdr_pkg::REG_DUTY_CEILING || sel == tmdr_pkg::REG_DUTY_FLOOR) begin
      word[tmdr_pkg::DUTY_BITS-1:0] = value[tmdr_pkg::DUTY_BITS-1:0];
      stored = word & 32'h0000_007F;
    end else begin
      word[tmdr_pkg::LEVEL_BITS-1:0] = value;
      stored = word & 32'h0000_0FFF;
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (sel)
      tmdr_pkg::REG_HIGH_LIMIT:   cfg_high    = stored[tmdr_pkg::LEVEL_BITS-1:0];
      tmdr_pkg::REG_LOW_LIMIT:    cfg_low     = stored[tmdr_pkg::LEVEL_BITS-1:0];
      tmdr_pkg::REG_DUTY_CEILING: cfg_ceiling = stored[tmdr_pkg::DUTY_BITS-1:0];
      tmdr_pkg::REG_DUTY_FLOOR:   cfg_floor   = stored[tmdr_pkg::DUTY_BITS-1:0];
      default: ;
    endcase
    register_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) begin
      $error("register %s readback: expected 0x%0h, got 0x%0h", sel.name(), stored, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    // idle so back-to-back writes never restart the bus in this step
    @(posedge clk);
  endtask

  // Pick a register setting: often an extreme, otherwise anywhere in range.
  function automatic logic [11:0] pick_setting(input int unsigned top);
    case ($urandom_range(0, 3))
      0:       return 12'd0;
      1:       return top[11:0];
      default: return 12'($urandom_range(0, top));
    endcase
  endfunction

  // Result checker: compare each accepted result item with the oldest
  // expectation. Sample at the edge, so only pre-edge values are seen.
  always @(posedge clk) begin
    level_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no sample pending: filtered_level %0d, duty %0d",
               m_tdata[11:0], m_tdata[18:12]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (m_tdata[11:0] !== want.level) begin
          $error("filtered_level: expected %0d, got %0d", want.level, m_tdata[11:0]);
          error_count++;
        end
        if (m_tuser[0] !== want.updated) begin
          $error("level_updated: expected %0d, got %0d", want.updated, m_tuser[0]);
          error_count++;
        end
        if (m_tdata[18:12] !== want.duty) begin
          $error("duty: expected %0d, got %0d", want.duty, m_tdata[18:12]);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if it ever hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: stall in segments of random density, some with no stall at
  // all. On request, cut the segment short and hold off for a long stretch
  // so the block backs up and drops s_tready while the sender keeps offering.
  initial begin
    int unsigned seg_len;
    int unsigned stall_pct;
    @(posedge clk);
    forever begin
      if (hold_taken != hold_asked) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_taken++;
      end else begin
        seg_len = $urandom_range(10, 150);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 30;
          3:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
        repeat (seg_len) begin
          if (hold_taken != hold_asked) break;
          m_tready <= ($urandom_range(0, 99) >= stall_pct);
          @(posedge clk);
        end
      end
    end
  end

  // Main sequence: reset, stimulus table, random phases, drain, verdict.
  initial begin
    stim_row_t   row;
    int          phase_idx;
    int          sample_goal;
    int unsigned phase_left;
    int unsigned style;
    int unsigned spread;
    int          base;
    int          level_try;
    logic [11:0] smp;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        settle_pipeline();
        program_register(row.sel, row.value);
      end else begin
        offer_sample(row.value, row.typed, row.want);
      end
    end

    // Random phases. Phase 0 runs a long under-limit stretch with a low
    // ceiling; phase 1 lifts the ceiling so the raise resumes, stops at the
    // counter wrap and restarts after six more low steps. Later phases pick
    // every register afresh; phase 3 carries the long receiver hold-off.
    sample_goal = samples_sent + RANDOM_ITEMS;
    phase_idx   = 0;
    while (samples_sent < sample_goal) begin
      settle_pipeline();
      if (phase_idx == 0) begin
        program_register(tmdr_pkg::REG_HIGH_LIMIT, 12'd4095);
        program_register(tmdr_pkg::REG_LOW_LIMIT, 12'd4095);
        program_register(tmdr_pkg::REG_DUTY_CEILING, 12'd40);
        program_register(tmdr_pkg::REG_DUTY_FLOOR, 12'd0);
        phase_left = 250;
      end else if (phase_idx == 1) begin
        program_register(tmdr_pkg::REG_DUTY_CEILING, 12'd127);
        phase_left = 40;
      end else begin
        program_register(tmdr_pkg::REG_HIGH_LIMIT, pick_setting(4095));
        program_register(tmdr_pkg::REG_LOW_LIMIT, pick_setting(4095));
        program_register(tmdr_pkg::REG_DUTY_CEILING, pick_setting(127));
        program_register(tmdr_pkg::REG_DUTY_FLOOR, pick_setting(127));
        phase_left = $urandom_range(40, 250);
      end
      if (phase_idx == 3) hold_asked++;

      // Build whole windows: mostly a cluster around a random level with
      // the odd full-scale spike, sometimes flat at an extreme or noise.
      while (phase_left > 0 && samples_sent < sample_goal) begin
        style  = $urandom_range(0, 9);
        base   = $urandom_range(0, 4095);
        spread = $urandom_range(0, 255);
        for (int j = 0; j < 10 && phase_left > 0 && samples_sent < sample_goal; j++) begin
          case (style)
            0: smp = 12'($urandom_range(0, 4095));
            1: smp = 12'd4095;
            2: smp = 12'd0;
            default: begin
              level_try = base + int'($urandom_range(0, 2 * spread)) - int'(spread);
              if (level_try < 0) level_try = 0;
              if (level_try > 4095) level_try = 4095;
              smp = level_try[11:0];
              if ($urandom_range(0, 15) == 0) smp = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
            end
          endcase
          offer_sample(smp, 1'b0, '0);
          phase_left--;
        end
      end
      phase_idx++;
    end

    settle_pipeline();
    repeat (END_CYCLES) @(posedge clk);

    $display("Covered %0d samples, %0d windows closed, %0d register writes over %0d phases.",
             samples_sent, windows_closed, register_writes, phase_idx);
    $display("Checked %0d results; duty raised %0d and cut %0d times, under run wrapped %0d.",
             results_checked, duty_raises, duty_cuts, under_wraps);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tmdr_pkg.sv
rtl/trimmed_mean_duty_regulator_core.sv
rtl/tmdr_checker.sv
bench/testbench.sv
